### rtl/mpd_pkg.sv
// Shared types and constants for the MQTT packet deframer.
package mpd_pkg;

  localparam int unsigned LEN_W = 29;
  localparam int unsigned ACC_W = 28;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_BIG   = 2'd2;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 29'd4096;

  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] frame_length;
    logic [1:0]       status;
  } mpd_result_t;

endpackage

### rtl/mpd_front.sv
// Front part: accepts bytes, tracks packet framing and classifies each byte.
module mpd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mpd_pkg::LEN_W-1:0]  cfg_max_packet_length,
  input  logic                       q_full,
  output logic                       q_push,
  output mpd_pkg::mpd_result_t       q_data
);
  import mpd_pkg::*;

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;
  localparam logic [2:0] MAX_LEN_BYTES = 3'd4;

  logic [1:0]       phase_r, phase_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [LEN_W-1:0] exp_r, exp_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [LEN_W-1:0] max_r;

  logic [ACC_W-1:0] acc_add;
  logic [ACC_W-1:0] acc_new;
  logic [2:0]       cnt_inc;
  logic [LEN_W-1:0] seen_inc;
  logic [LEN_W-1:0] total;
  logic             accept;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    acc_add = {21'd0, in_rx_byte[6:0]};
      2'd1:    acc_add = {14'd0, in_rx_byte[6:0], 7'd0};
      2'd2:    acc_add = {7'd0, in_rx_byte[6:0], 14'd0};
      default: acc_add = {in_rx_byte[6:0], 21'd0};
    endcase
  end

  assign acc_new  = acc_r | acc_add;
  assign cnt_inc  = cnt_r + 3'd1;
  assign seen_inc = seen_r + 29'd1;
  assign total    = 29'd1 + {26'd0, cnt_inc} + {1'b0, acc_new};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    exp_nxt   = exp_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    q_data.data         = in_rx_byte;
    q_data.first        = 1'b0;
    q_data.last         = 1'b0;
    q_data.frame_length = '0;
    q_data.status       = ST_OK;
    case (phase_r)
      PH_TYPE: begin
        acc_nxt      = '0;
        cnt_nxt      = '0;
        exp_nxt      = '0;
        seen_nxt     = 29'd1;
        q_data.first = 1'b1;
        phase_nxt    = PH_LEN;
      end
      PH_LEN: begin
        if (cnt_r >= MAX_LEN_BYTES) begin
          err_nxt       = ST_MALFORMED;
          phase_nxt     = PH_ERR;
          q_data.status = ST_MALFORMED;
        end else begin
          acc_nxt  = acc_new;
          cnt_nxt  = cnt_inc;
          seen_nxt = seen_inc;
          if (!in_rx_byte[7]) begin
            exp_nxt = total;
            if (total > max_r) begin
              err_nxt       = ST_TOO_BIG;
              phase_nxt     = PH_ERR;
              q_data.status = ST_TOO_BIG;
            end else if (seen_inc == total) begin
              q_data.last         = 1'b1;
              q_data.frame_length = total;
              phase_nxt           = PH_TYPE;
              acc_nxt             = '0;
              cnt_nxt             = '0;
              exp_nxt             = '0;
              seen_nxt            = '0;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        seen_nxt = seen_inc;
        if (seen_inc >= exp_r) begin
          q_data.last         = 1'b1;
          q_data.frame_length = exp_r;
          phase_nxt           = PH_TYPE;
          acc_nxt             = '0;
          cnt_nxt             = '0;
          exp_nxt             = '0;
          seen_nxt            = '0;
        end
      end
      default: begin
        q_data.status = err_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      acc_r   <= '0;
      cnt_r   <= '0;
      exp_r   <= '0;
      seen_r  <= '0;
      err_r   <= ST_OK;
      max_r   <= MAX_LEN_RESET;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        cnt_r   <= cnt_nxt;
        exp_r   <= exp_nxt;
        seen_r  <= seen_nxt;
        err_r   <= err_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        max_r <= cfg_max_packet_length;
      end
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERR |=> phase_r == PH_ERR)
    else $error("error phase left without reset");

  a_last_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.last |-> q_data.frame_length != '0 && q_data.status == ST_OK)
    else $error("last byte without a frame length");

endmodule

### rtl/mpd_fifo.sv
// Two-entry queue that holds classified bytes between the front and back parts.
module mpd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mpd_pkg::mpd_result_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output mpd_pkg::mpd_result_t pop_data
);
  import mpd_pkg::*;

  mpd_result_t mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule

### rtl/mpd_back.sv
// Back part: output register that presents each classified byte as a result transaction.
module mpd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_not_empty,
  input  mpd_pkg::mpd_result_t       q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_first_of_packet,
  output logic                       out_last_of_packet,
  output logic [mpd_pkg::LEN_W-1:0]  out_frame_length,
  output logic [1:0]                 out_status
);
  import mpd_pkg::*;

  logic        valid_r;
  mpd_result_t res_r;

  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
  end

  assign out_valid           = valid_r;
  assign out_byte            = res_r.data;
  assign out_first_of_packet = res_r.first;
  assign out_last_of_packet  = res_r.last;
  assign out_frame_length    = res_r.frame_length;
  assign out_status          = res_r.status;

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(res_r))
    else $error("result changed while stalled");

endmodule

### rtl/mqtt_packet_deframer_unit.sv
// Top level of the MQTT packet deframer.
// The unit takes one stream byte per clock cycle while its queue is not full and returns one
// result transaction per byte: the classifier updates the framing state and writes the byte
// into a two-entry queue at the accepting edge, and the output register takes it from the
// queue whenever that register is empty or its current result is being accepted. Each result
// carries the byte with first and last marks, the packet's total length on its last byte, and
// a status that becomes sticky after a malformed length field or an oversized packet until
// reset. The maximum packet length register may be written at any time the unit is idle and
// resets to 4096.
module mqtt_packet_deframer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_first_of_packet,
  output logic                       out_last_of_packet,
  output logic [mpd_pkg::LEN_W-1:0]  out_frame_length,
  output logic [1:0]                 out_status,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mpd_pkg::LEN_W-1:0]  cfg_max_packet_length
);
  import mpd_pkg::*;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  mpd_result_t q_in;
  mpd_result_t q_out;

  mpd_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_max_packet_length (cfg_max_packet_length),
    .q_full                (q_full),
    .q_push                (q_push),
    .q_data                (q_in)
  );

  mpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  mpd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_not_empty         (q_not_empty),
    .q_data              (q_out),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_first_of_packet (out_first_of_packet),
    .out_last_of_packet  (out_last_of_packet),
    .out_frame_length    (out_frame_length),
    .out_status          (out_status)
  );

endmodule

### verif/mqtt_packet_deframer_unit_tb.sv
// Self-checking testbench for the MQTT packet deframer with its own framing predictor.
module mqtt_packet_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;

  typedef enum logic [1:0] {
    WANT_TYPE,
    WANT_LENGTH,
    WANT_BODY,
    LATCHED_ERROR
  } frame_phase_e;

  typedef struct {
    logic [7:0]  rx;
    bit          typed;
    mpd_result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam int unsigned LEN_FIELD_MAX = 4;
  localparam int unsigned NORMAL_BYTES = 1850;
  localparam int unsigned PHASE_BYTES = 150;
  localparam int unsigned TAIL_BYTES = 150;
  localparam logic [LEN_W-1:0] CAP_FLOOR = 29'd2;
  localparam logic [LEN_W-1:0] CAP_TOP = 29'd268435460;
  localparam logic [LEN_W-1:0] CAP_ALL_ONES = 29'h1FFFFFFF;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_byte;
  logic             out_first_of_packet;
  logic             out_last_of_packet;
  logic [LEN_W-1:0] out_frame_length;
  logic [1:0]       out_status;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_max_packet_length = MAX_LEN_RESET;

  frame_phase_e     fr_phase = WANT_TYPE;
  logic [ACC_W-1:0] fr_acc = '0;
  logic [2:0]       fr_len_bytes = '0;
  logic [LEN_W-1:0] fr_total = '0;
  logic [LEN_W-1:0] fr_seen = '0;
  logic [1:0]       fr_err = ST_OK;
  logic [LEN_W-1:0] fr_max_len = MAX_LEN_RESET;

  mpd_result_t pending_results[$];
  mpd_result_t want_now;
  int unsigned mismatch_count = 0;
  int unsigned bytes_driven = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 29'd0, ST_OK}},
    '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 29'd2, ST_OK}},
    '{8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 29'd0, ST_OK}},
    '{8'h01, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h30, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h10, 1'b0, '0},
    '{8'h81, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'hC0, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h00, 1'b0, '0}
  };

  mqtt_packet_deframer_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_byte              (out_byte),
    .out_first_of_packet   (out_first_of_packet),
    .out_last_of_packet    (out_last_of_packet),
    .out_frame_length      (out_frame_length),
    .out_status            (out_status),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_max_packet_length (cfg_max_packet_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_frame();
    fr_acc = '0;
    fr_len_bytes = '0;
    fr_total = '0;
    fr_seen = '0;
  endfunction

  function automatic mpd_result_t deframe_byte(input logic [7:0] b);
    mpd_result_t r;
    r = '0;
    r.data = b;
    r.status = ST_OK;
    case (fr_phase)
      WANT_TYPE: begin
        clear_frame();
        fr_seen = 29'd1;
        r.first = 1'b1;
        fr_phase = WANT_LENGTH;
      end
      WANT_LENGTH: begin
        if (fr_len_bytes >= LEN_FIELD_MAX) begin
          fr_err = ST_MALFORMED;
          fr_phase = LATCHED_ERROR;
          r.status = fr_err;
        end else begin
          fr_acc = fr_acc | (ACC_W'(b[6:0]) << (7 * fr_len_bytes));
          fr_len_bytes = fr_len_bytes + 3'd1;
          fr_seen = fr_seen + 29'd1;
          if (!b[7]) begin
            fr_total = LEN_W'(fr_acc) + LEN_W'(fr_len_bytes) + 29'd1;
            if (fr_total > fr_max_len) begin
              fr_err = ST_TOO_BIG;
              fr_phase = LATCHED_ERROR;
              r.status = fr_err;
            end else if (fr_seen == fr_total) begin
              r.last = 1'b1;
              r.frame_length = fr_total;
              fr_phase = WANT_TYPE;
              clear_frame();
            end else begin
              fr_phase = WANT_BODY;
            end
          end
        end
      end
      WANT_BODY: begin
        fr_seen = fr_seen + 29'd1;
        if (fr_seen >= fr_total) begin
          r.last = 1'b1;
          r.frame_length = fr_total;
          fr_phase = WANT_TYPE;
          clear_frame();
        end
      end
      default: begin
        r.status = fr_err;
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input mpd_result_t want = '0);
    int unsigned gap;
    mpd_result_t model;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model = deframe_byte(b);
    pending_results.push_back(typed ? want : model);
    bytes_driven++;
  endtask

  task automatic load_max_length(input logic [LEN_W-1:0] cap);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_packet_length <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fr_max_len = cap;
  endtask

  task automatic send_length(input int unsigned rem, input int unsigned nb);
    for (int unsigned i = 0; i < nb; i++) begin
      push_byte(8'(((rem >> (7 * i)) & 32'h7F) | ((i < nb - 1) ? 32'h80 : 32'h0)));
    end
  endtask

  task automatic send_packet(input logic [LEN_W-1:0] cap);
    int unsigned rem;
    int unsigned nb;
    int unsigned nmin;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) rem = $urandom_range(0, 12);
    else if (sel < 18) rem = $urandom_range(13, 200);
    else rem = $urandom_range(201, 400);
    nmin = (rem < 128) ? 1 : 2;
    nb = ($urandom_range(0, 3) == 0) ? $urandom_range(nmin, LEN_FIELD_MAX) : nmin;
    if (1 + nb + rem > cap) begin
      if (cap >= 1 + nb) begin
        rem = $urandom_range(0, cap - 1 - nb);
      end else begin
        nb = 1;
        rem = 0;
      end
    end
    push_byte(8'($urandom));
    send_length(rem, nb);
    repeat (rem) push_byte(8'($urandom));
  endtask

  function automatic logic [LEN_W-1:0] phase_cap(input int unsigned idx);
    logic [LEN_W-1:0] v;
    case (idx)
      0: return MAX_LEN_RESET;
      1: return CAP_FLOOR;
      2: return CAP_ALL_ONES;
      3: return CAP_TOP;
      default: begin
        case ($urandom_range(0, 2))
          0: v = LEN_W'($urandom_range(2, 64));
          1: v = LEN_W'($urandom_range(65, 6000));
          default: v = LEN_W'($urandom);
        endcase
        if (v < CAP_FLOOR) v = CAP_FLOOR;
        return v;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("out_byte: expected no transaction, actual %0h", out_byte);
        mismatch_count++;
      end else begin
        want_now = pending_results.pop_front();
        if (out_byte !== want_now.data) begin
          $error("out_byte: expected %0h, actual %0h", want_now.data, out_byte);
          mismatch_count++;
        end
        if (out_first_of_packet !== want_now.first) begin
          $error("out_first_of_packet: expected %0d, actual %0d",
                 want_now.first, out_first_of_packet);
          mismatch_count++;
        end
        if (out_last_of_packet !== want_now.last) begin
          $error("out_last_of_packet: expected %0d, actual %0d",
                 want_now.last, out_last_of_packet);
          mismatch_count++;
        end
        if (out_frame_length !== want_now.frame_length) begin
          $error("out_frame_length: expected %0d, actual %0d",
                 want_now.frame_length, out_frame_length);
          mismatch_count++;
        end
        if (out_status !== want_now.status) begin
          $error("out_status: expected %0d, actual %0d", want_now.status, out_status);
          mismatch_count++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 9) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    int unsigned phase_idx;
    int unsigned phase_start;
    int unsigned rem;
    int unsigned nb;
    logic [LEN_W-1:0] cap;
    phase_idx = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_byte(dir_table[i].rx, dir_table[i].typed, dir_table[i].want);
    end
    while (bytes_driven < NORMAL_BYTES) begin
      cap = phase_cap(phase_idx);
      load_max_length(cap);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_start = bytes_driven;
      while (bytes_driven - phase_start < PHASE_BYTES && bytes_driven < NORMAL_BYTES) begin
        send_packet(cap);
      end
      phase_idx++;
    end
    no_idle = 1'b0;
    if ($urandom_range(0, 1) == 0) begin
      push_byte(8'($urandom));
      repeat (LEN_FIELD_MAX) push_byte(8'($urandom_range(128, 255)));
      push_byte(8'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          cap = LEN_W'($urandom_range(0, 1));
          rem = 0;
          nb = 1;
        end
        1: begin
          cap = LEN_W'($urandom_range(2, 1000));
          rem = cap;
          nb = (rem < 128) ? 1 : 2;
        end
        default: begin
          cap = CAP_TOP - 29'd1;
          rem = 32'h0FFFFFFF;
          nb = LEN_FIELD_MAX;
        end
      endcase
      load_max_length(cap);
      push_byte(8'($urandom));
      send_length(rem, nb);
    end
    repeat (TAIL_BYTES) push_byte(8'($urandom));
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("mqtt_packet_deframer_unit_tb OK");
    end else begin
      $display("mqtt_packet_deframer_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("mqtt_packet_deframer_unit_tb NOT OK");
    $finish;
  end

endmodule

### sim.f
rtl/mpd_pkg.sv
rtl/mpd_front.sv
rtl/mpd_fifo.sv
rtl/mpd_back.sv
rtl/mqtt_packet_deframer_unit.sv
verif/mqtt_packet_deframer_unit_tb.sv
